// ===== rtl/eds_pkg.sv =====
package eds_pkg;

    // Default grid capacity.
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Field and register widths.
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 16;
    localparam int SIZE_W     = 11;
    localparam int IDX_W      = 10;
    localparam int OPCODE_W   = 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 16;

    // Arithmetic widths: Laplacian term, coefficient product and full sum.
    localparam int LAP_W  = DATA_W + 2;
    localparam int PROD_W = LAP_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // Queue between the front and back ends.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Reset values of the grid size registers.
    localparam logic [SIZE_W-1:0] RST_GRID_ROWS = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] RST_GRID_COLS = SIZE_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_X    = 3'd0,
        CFG_COEF_Y    = 3'd1,
        CFG_BOUNDARY  = 3'd2,
        CFG_GRID_ROWS = 3'd3,
        CFG_GRID_COLS = 3'd4
    } t_cfg_reg;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    // One stencil job: the center and its four neighbors, plus result tags.
    typedef struct packed {
        logic signed [DATA_W-1:0] ctr;
        logic signed [DATA_W-1:0] west;
        logic signed [DATA_W-1:0] east;
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] south;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } t_job;

endpackage

// ===== rtl/eds_in_if.sv =====
interface eds_in_if;
    import eds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic signed [DATA_W-1:0] cell_value;

    modport source (output valid, output opcode, output cell_value, input ready);
    modport sink (input valid, input opcode, input cell_value, output ready);

endinterface

// ===== rtl/eds_out_if.sv =====
interface eds_out_if;
    import eds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last_of_grid;

    modport source (
        output valid, output new_value, output out_row, output out_col,
        output last_of_grid, input ready
    );
    modport sink (
        input valid, input new_value, input out_row, input out_col,
        input last_of_grid, output ready
    );

endinterface

// ===== rtl/explicit_diffusion_stencil_2d.sv =====
// A result passes the read stage, the job queue, back-end stages b1 to b3 and
// the output register; row-0 loads give no result. Throughput: one request
// per cycle while the job queue has room, set by one write and one read per
// row store per request and the four-stage multiply and round pipe.
// Reset (synchronous, active low) clears position, queue, pipe valids and
// configuration; row store contents stay undefined until written.
module explicit_diffusion_stencil_2d #(
    parameter int MAX_COLS = eds_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = eds_pkg::DEF_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    eds_in_if.sink                         i_req,
    eds_out_if.source                      o_res,
    input  logic                           i_cfg_wr_en,
    input  logic [eds_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [eds_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import eds_pkg::*;

    logic [COEF_W-1:0]        r_coef_x;
    logic [COEF_W-1:0]        r_coef_y;
    logic signed [DATA_W-1:0] r_boundary;
    logic [SIZE_W-1:0]        r_grid_rows;
    logic [SIZE_W-1:0]        r_grid_cols;

    logic            q_push;
    t_job            q_job_in;
    t_job            q_job_out;
    logic            q_valid;
    logic            q_pop;
    logic [Q_CW-1:0] q_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x    <= '0;
            r_coef_y    <= '0;
            r_boundary  <= '0;
            r_grid_rows <= RST_GRID_ROWS;
            r_grid_cols <= RST_GRID_COLS;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_COEF_X:    r_coef_x    <= i_cfg_wdata[COEF_W-1:0];
                CFG_COEF_Y:    r_coef_y    <= i_cfg_wdata[COEF_W-1:0];
                CFG_BOUNDARY:  r_boundary  <= i_cfg_wdata[DATA_W-1:0];
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_wdata[SIZE_W-1:0];
                CFG_GRID_COLS: r_grid_cols <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: position tracking, row stores, neighbor gathering.
    eds_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_boundary  (r_boundary),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_q_count   (q_count),
        .o_push      (q_push),
        .o_job       (q_job_in)
    );

    // Job queue between the two ends.
    eds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_job_in),
        .i_pop   (q_pop),
        .o_data  (q_job_out),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    // Back end: stencil arithmetic and output register.
    eds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job_out),
        .o_pop       (q_pop),
        .i_coef_x    (r_coef_x),
        .i_coef_y    (r_coef_y),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/eds_ram.sv =====
module eds_ram #(
    parameter int WIDTH = eds_pkg::DATA_W,
    parameter int DEPTH = eds_pkg::DEF_MAX_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read-first memory: a read of the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/eds_front.sv =====
module eds_front #(
    parameter int MAX_COLS = eds_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = eds_pkg::DEF_MAX_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    eds_in_if.sink                           i_req,
    input  logic signed [eds_pkg::DATA_W-1:0] i_boundary,
    input  logic [eds_pkg::SIZE_W-1:0]       i_grid_rows,
    input  logic [eds_pkg::SIZE_W-1:0]       i_grid_cols,
    input  logic [eds_pkg::Q_CW-1:0]         i_q_count,
    output logic                             o_push,
    output eds_pkg::t_job                    o_job
);
    import eds_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic signed [DATA_W-1:0] r_prev_ctr;

    logic                     accept;
    logic                     is_flush;
    logic                     col_last;
    logic                     emit;
    logic [RW-1:0]            erow;
    logic signed [DATA_W-1:0] east;
    logic signed [DATA_W-1:0] north;
    logic signed [DATA_W-1:0] older_rdata;
    logic signed [DATA_W-1:0] newer_rdata;

    logic                     r_s1_valid;
    logic signed [DATA_W-1:0] r_s1_ctr;
    logic signed [DATA_W-1:0] r_s1_east;
    logic signed [DATA_W-1:0] r_s1_north;
    logic                     r_s1_west_bnd;
    logic                     r_s1_south_bnd;
    logic [IDX_W-1:0]         r_s1_row;
    logic [IDX_W-1:0]         r_s1_col;
    logic                     r_s1_last;

    // Clamp the configured grid size to the supported range.
    always_comb begin
        if (i_grid_cols < SIZE_W'(2)) begin
            last_col = CW'(1);
        end else if (32'(i_grid_cols) > 32'(MAX_COLS)) begin
            last_col = CW'(MAX_COLS - 1);
        end else begin
            last_col = CW'(i_grid_cols - 1'b1);
        end
        if (i_grid_rows < SIZE_W'(2)) begin
            last_row = RW'(1);
        end else if (32'(i_grid_rows) > 32'(MAX_ROWS)) begin
            last_row = RW'(MAX_ROWS - 1);
        end else begin
            last_row = RW'(i_grid_rows - 1'b1);
        end
    end

    // Take a request only when the queue has room for everything in flight.
    assign i_req.ready = (i_q_count + Q_CW'(r_s1_valid)) < Q_CW'(Q_DEPTH);
    assign accept      = i_req.valid && i_req.ready;

    // Classify the request and work out the next grid position.
    always_comb begin
        is_flush = (i_req.opcode == OP_FLUSH);
        east     = is_flush ? i_boundary : i_req.cell_value;
        col_last = (r_col >= last_col);
        erow     = (r_row == '0) ? last_row : r_row - 1'b1;
        emit     = is_flush || (r_row != '0);
        north    = (r_col == '0) ? i_boundary : r_prev_ctr;
        if (col_last) begin
            n_col = '0;
            n_row = (is_flush || r_row >= last_row) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // The center value is the newer-row word fetched by the previous request.
    // The older row takes it, the newer row takes the incoming cell or, on a flush, the boundary.
    eds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_COLS)
    ) u_older (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (newer_rdata),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (older_rdata)
    );

    // Prefetch the word at the next position: it is this cell's south
    // neighbor and the center of the next request.
    eds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_COLS)
    ) u_newer (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (east),
        .i_rd_en   (accept),
        .i_rd_addr (n_col),
        .o_rd_data (newer_rdata)
    );

    // Position counters and the north neighbor carried along the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_ctr <= newer_rdata;
        end
    end

    // Stage that waits for the memory reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctr       <= newer_rdata;
            r_s1_east      <= east;
            r_s1_north     <= north;
            r_s1_west_bnd  <= (erow == '0);
            r_s1_south_bnd <= col_last;
            r_s1_row       <= IDX_W'(erow);
            r_s1_col       <= IDX_W'(r_col);
            r_s1_last      <= (erow == last_row) && col_last;
        end
    end

    // Assemble the job with the neighbors read from the row stores.
    always_comb begin
        o_job.ctr   = r_s1_ctr;
        o_job.west  = r_s1_west_bnd ? i_boundary : older_rdata;
        o_job.east  = r_s1_east;
        o_job.north = r_s1_north;
        o_job.south = r_s1_south_bnd ? i_boundary : newer_rdata;
        o_job.row   = r_s1_row;
        o_job.col   = r_s1_col;
        o_job.last  = r_s1_last;
    end

    assign o_push = r_s1_valid;

endmodule

// ===== rtl/eds_queue.sv =====
module eds_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  eds_pkg::t_job            i_data,
    input  logic                     i_pop,
    output eds_pkg::t_job            o_data,
    output logic                     o_valid,
    output logic [eds_pkg::Q_CW-1:0] o_count
);
    import eds_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;

    // Storage; the front end never pushes into a full queue.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

// ===== rtl/eds_back.sv =====
module eds_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  eds_pkg::t_job              i_job,
    output logic                       o_pop,
    input  logic [eds_pkg::COEF_W-1:0] i_coef_x,
    input  logic [eds_pkg::COEF_W-1:0] i_coef_y,
    eds_out_if.source                  o_res
);
    import eds_pkg::*;

    localparam int QUO_W = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic en;

    logic signed [LAP_W-1:0]  ctr2;
    logic signed [LAP_W-1:0]  lap_x;
    logic signed [LAP_W-1:0]  lap_y;
    logic signed [COEF_W:0]   kx;
    logic signed [COEF_W:0]   ky;
    logic [QUO_W-1:0]         quo;
    logic                     ovf_hi;
    logic                     ovf_lo;
    logic [DATA_W-1:0]        sat;

    logic                     r_b1_valid;
    logic signed [LAP_W-1:0]  r_b1_lx;
    logic signed [LAP_W-1:0]  r_b1_ly;
    logic signed [DATA_W-1:0] r_b1_ctr;
    logic [IDX_W-1:0]         r_b1_row;
    logic [IDX_W-1:0]         r_b1_col;
    logic                     r_b1_last;

    logic                     r_b2_valid;
    logic signed [PROD_W-1:0] r_b2_px;
    logic signed [PROD_W-1:0] r_b2_py;
    logic signed [DATA_W-1:0] r_b2_ctr;
    logic [IDX_W-1:0]         r_b2_row;
    logic [IDX_W-1:0]         r_b2_col;
    logic                     r_b2_last;

    logic                     r_b3_valid;
    logic signed [SUM_W-1:0]  r_b3_sum;
    logic [IDX_W-1:0]         r_b3_row;
    logic [IDX_W-1:0]         r_b3_col;
    logic                     r_b3_last;

    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_new_value;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic                     r_out_last;

    // The whole pipe moves unless the output register holds an untaken result.
    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en && i_job_valid;

    // Second differences along each axis.
    always_comb begin
        ctr2  = LAP_W'($signed(i_job.ctr)) <<< 1;
        lap_x = LAP_W'($signed(i_job.east)) + LAP_W'($signed(i_job.west)) - ctr2;
        lap_y = LAP_W'($signed(i_job.south)) + LAP_W'($signed(i_job.north)) - ctr2;
        kx    = $signed({1'b0, i_coef_x});
        ky    = $signed({1'b0, i_coef_y});
    end

    // Round to nearest and clamp to the signed 32-bit range.
    always_comb begin
        quo    = r_b3_sum[SUM_W-1:FRAC_W];
        ovf_hi = !quo[QUO_W-1] && (|quo[QUO_W-2:DATA_W-1]);
        ovf_lo = quo[QUO_W-1] && !(&quo[QUO_W-2:DATA_W-1]);
        if (ovf_hi) begin
            sat = SAT_MAX;
        end else if (ovf_lo) begin
            sat = SAT_MIN;
        end else begin
            sat = quo[DATA_W-1:0];
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= i_job_valid;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_out_valid <= r_b3_valid;
        end
    end

    // Datapath: Laplacians, coefficient products, sum, saturation.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_lx     <= lap_x;
            r_b1_ly     <= lap_y;
            r_b1_ctr    <= i_job.ctr;
            r_b1_row    <= i_job.row;
            r_b1_col    <= i_job.col;
            r_b1_last   <= i_job.last;

            r_b2_px     <= r_b1_lx * kx;
            r_b2_py     <= r_b1_ly * ky;
            r_b2_ctr    <= r_b1_ctr;
            r_b2_row    <= r_b1_row;
            r_b2_col    <= r_b1_col;
            r_b2_last   <= r_b1_last;

            r_b3_sum    <= (SUM_W'($signed(r_b2_ctr)) <<< FRAC_W) + SUM_W'(r_b2_px)
                           + SUM_W'(r_b2_py) + ROUND_HALF;
            r_b3_row    <= r_b2_row;
            r_b3_col    <= r_b2_col;
            r_b3_last   <= r_b2_last;

            r_new_value <= sat;
            r_out_row   <= r_b3_row;
            r_out_col   <= r_b3_col;
            r_out_last  <= r_b3_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.new_value    = r_new_value;
    assign o_res.out_row      = r_out_row;
    assign o_res.out_col      = r_out_col;
    assign o_res.last_of_grid = r_out_last;

endmodule

// ===== rtl/eds_checker.sv =====
module eds_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [eds_pkg::DATA_W-1:0]   i_out_new_value,
    input logic [eds_pkg::IDX_W-1:0]    i_out_row,
    input logic [eds_pkg::IDX_W-1:0]    i_out_col,
    input logic                         i_out_last
);
    import eds_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_W      = $clog2(DRAIN_CYCLES + 1);

    logic [QUIET_W-1:0] r_quiet;

    // Count cycles with no new request while the output side keeps taking results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet <= '0;
        end else if ((i_in_valid && i_in_ready) || !i_out_ready) begin
            r_quiet <= '0;
        end else if (r_quiet != QUIET_W'(DRAIN_CYCLES)) begin
            r_quiet <= r_quiet + 1'b1;
        end
    end

    // No result appears before a request taken after reset has passed the whole pipe.
    a_startup_quiet: assert property (@(posedge i_clk)
        (!$past(i_rst_n, 1) || !$past(i_rst_n, 2) || !$past(i_rst_n, 3)
         || !$past(i_rst_n, 4) || !$past(i_rst_n, 5)) |-> !i_out_valid)
        else $error("result shown too soon after reset");

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_new_value)
            && $stable(i_out_row) && $stable(i_out_col) && $stable(i_out_last)))
        else $error("stalled result changed or dropped");

    // With no new requests and a ready sink, the block drains completely.
    a_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_quiet == QUIET_W'(DRAIN_CYCLES)) |-> !i_out_valid)
        else $error("result shown with no request left in flight");

endmodule

bind explicit_diffusion_stencil_2d eds_checker u_eds_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_new_value (o_res.new_value),
    .i_out_row       (o_res.out_row),
    .i_out_col       (o_res.out_col),
    .i_out_last      (o_res.last_of_grid)
);

// ===== tb/tb_explicit_diffusion_stencil_2d.sv =====
module tb_explicit_diffusion_stencil_2d;
    import eds_pkg::*;

    localparam int          GRID_CAP      = DEF_MAX_COLS;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 80;
    localparam int unsigned RANDOM_ITEMS  = 1700;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    // One updated grid cell as the result side should deliver it.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } cell_result_t;

    // Tracks the block's row stores and position, and queues the cells it should emit.
    class stencil_scoreboard;
        logic [COEF_W-1:0]        coef_x;
        logic [COEF_W-1:0]        coef_y;
        logic signed [DATA_W-1:0] bnd;
        logic [SIZE_W-1:0]        rows_reg;
        logic [SIZE_W-1:0]        cols_reg;
        logic signed [DATA_W-1:0] older_row [GRID_CAP];
        logic signed [DATA_W-1:0] newer_row [GRID_CAP];
        bit                       older_ok [GRID_CAP];
        bit                       newer_ok [GRID_CAP];
        int unsigned              row_pos;
        int unsigned              col_pos;
        int unsigned              accepted;
        int unsigned              mismatches;
        cell_result_t             pending_cells [$];

        function new();
            coef_x     = '0;
            coef_y     = '0;
            bnd        = '0;
            rows_reg   = RST_GRID_ROWS;
            cols_reg   = RST_GRID_COLS;
            row_pos    = 0;
            col_pos    = 0;
            accepted   = 0;
            mismatches = 0;
            foreach (older_ok[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
                older_ok[i]  = 1'b0;
                newer_ok[i]  = 1'b0;
            end
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 2) return 2;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned rows_in_use();
            return clamp_size(rows_reg, DEF_MAX_ROWS);
        endfunction

        function int unsigned cols_in_use();
            return clamp_size(cols_reg, DEF_MAX_COLS);
        endfunction

        function int unsigned cur_col();
            return (col_pos >= GRID_CAP) ? GRID_CAP - 1 : col_pos;
        endfunction

        // The row whose results come out with the next request.
        function int unsigned emit_row();
            return (row_pos == 0) ? rows_in_use() - 1 : row_pos - 1;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COEF_X:    coef_x   = data[COEF_W-1:0];
                CFG_COEF_Y:    coef_y   = data[COEF_W-1:0];
                CFG_BOUNDARY:  bnd      = data[DATA_W-1:0];
                CFG_GRID_ROWS: rows_reg = data[SIZE_W-1:0];
                CFG_GRID_COLS: cols_reg = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // True when the next request of this kind would read a store entry never written.
        function bit reads_unwritten(t_opcode op);
            int unsigned c;
            c = cur_col();
            if (op == OP_LOAD && row_pos == 0) return 1'b0;
            if (!newer_ok[c]) return 1'b1;
            if (emit_row() != 0 && !older_ok[c]) return 1'b1;
            if (c != 0 && !older_ok[c - 1]) return 1'b1;
            if (c + 1 < cols_in_use() && !newer_ok[c + 1]) return 1'b1;
            return 1'b0;
        endfunction

        // FTCS update: exact sum in 64 bits, round half up, saturate to 32 bits.
        function logic signed [DATA_W-1:0] ftcs_update(longint ctr, longint w, longint e,
                                                       longint n, longint s);
            longint lap_x;
            longint lap_y;
            longint acc;
            longint q;
            lap_x = e - 2 * ctr + w;
            lap_y = s - 2 * ctr + n;
            acc   = ctr * 65536 + lap_x * longint'(coef_x) + lap_y * longint'(coef_y);
            q     = (acc + 32768) >>> FRAC_W;
            if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (q < -64'sd2147483648) return 32'sh80000000;
            return q[DATA_W-1:0];
        endfunction

        function void note_request(t_opcode op, logic signed [DATA_W-1:0] cell_in);
            int unsigned              rows;
            int unsigned              cols;
            int unsigned              r;
            int unsigned              c;
            int unsigned              er;
            logic signed [DATA_W-1:0] east;
            longint                   w;
            longint                   n;
            longint                   s;
            cell_result_t             want;
            rows = rows_in_use();
            cols = cols_in_use();
            r    = row_pos;
            c    = cur_col();
            er   = emit_row();
            east = (op == OP_FLUSH) ? bnd : cell_in;
            accepted++;

            // Loads of row 0 only fill the store; everything else emits one cell.
            if (op == OP_FLUSH || r != 0) begin
                w = (er == 0) ? bnd : older_row[c];
                n = (c == 0) ? bnd : older_row[c - 1];
                s = (c + 1 >= cols) ? bnd : newer_row[c + 1];
                want.value = ftcs_update(newer_row[c], w, east, n, s);
                want.row   = er[IDX_W-1:0];
                want.col   = c[IDX_W-1:0];
                want.last  = (er == rows - 1 && c + 1 >= cols);
                pending_cells.push_back(want);
            end

            older_row[c] = newer_row[c];
            older_ok[c]  = newer_ok[c];
            newer_row[c] = east;
            newer_ok[c]  = 1'b1;

            // A position past the last column wraps; a flush that ends a row returns to row 0.
            if (c + 1 >= cols) begin
                col_pos = 0;
                row_pos = (op == OP_FLUSH || r + 1 >= rows) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void check_result(logic signed [DATA_W-1:0] value, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col, logic last);
            cell_result_t want;
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d row %0d col %0d last %0b",
                             value, row, col, last);
            end else begin
                want = pending_cells.pop_front();
                if (value !== want.value || row !== want.row || col !== want.col ||
                    last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected value %0d row %0d col %0d last %0b, %s",
                                 want.value, want.row, want.col, want.last,
                                 $sformatf("got value %0d row %0d col %0d last %0b",
                                           value, row, col, last));
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    eds_in_if  req_if ();
    eds_out_if res_if ();

    stencil_scoreboard board;
    bit                src_idle;
    bit                snk_idle;
    int unsigned       hold_asked;
    int unsigned       random_sent;

    explicit_diffusion_stencil_2d DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Cell values: corners, full-range noise and values of moderate size.
    function automatic logic signed [DATA_W-1:0] rand_cell();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) return 32'sh7FFFFFFF;
        if (pick < 8) return 32'sh80000000;
        if (pick < 10) return '0;
        if (pick < 40) return $urandom;
        return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return '0;
        if (pick < 30) return '1;
        if (pick < 60) return $urandom_range(0, 16'h2000);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // Writes one register; bits above the register's width are random.
    task automatic cfg_field(t_cfg_reg idx, int unsigned width, logic [CFG_DATA_W-1:0] field);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] data;
        mask = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1);
        data = ($urandom & ~mask) | (field & mask);
        @(negedge i_clk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    // Offers one request and waits until the block takes it.
    task automatic send_item(t_opcode op, logic signed [DATA_W-1:0] cell_in);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        // A flush in row 0 over stores not yet filled becomes a load.
        if (op == OP_FLUSH && board.row_pos == 0 && board.reads_unwritten(op))
            op = OP_LOAD;
        @(negedge i_clk);
        if (gap != 0) begin
            req_if.valid      = 1'b0;
            req_if.cell_value = $urandom;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.opcode     = op;
        req_if.cell_value = cell_in;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        board.note_request(op, cell_in);
    endtask

    // Flushes one cell per column to bring out the final row.
    task automatic flush_row();
        repeat (board.cols_in_use()) send_item(OP_FLUSH, $urandom);
    endtask

    // Loads cells until the grid wraps back to its first cell, then flushes.
    task automatic finish_grid();
        while (board.row_pos != 0 || board.col_pos != 0) send_item(OP_LOAD, rand_cell());
        flush_row();
    endtask

    task automatic run_grid();
        send_item(OP_LOAD, rand_cell());
        finish_grid();
    endtask

    // Drops valid, waits for every expected result and lets the pipe run empty.
    task automatic settle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (board.pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random register settings; with narrow_only the column count may not grow.
    task automatic random_config(bit narrow_only);
        int unsigned cols_now;
        int unsigned rows_w;
        int unsigned cols_w;
        cols_now = board.cols_in_use();
        rows_w   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
        cols_w   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
        if (narrow_only && cols_w > cols_now) cols_w = cols_now;
        if ($urandom_range(0, 3) != 0) cfg_field(CFG_COEF_X, COEF_W, rand_coef());
        if ($urandom_range(0, 3) != 0) cfg_field(CFG_COEF_Y, COEF_W, rand_coef());
        if ($urandom_range(0, 3) != 0) cfg_field(CFG_BOUNDARY, DATA_W, rand_cell());
        if ($urandom_range(0, 4) != 0) cfg_field(CFG_GRID_ROWS, SIZE_W, rows_w);
        if ($urandom_range(0, 4) != 0) cfg_field(CFG_GRID_COLS, SIZE_W, cols_w);
    endtask

    // Result side: takes results with random stalls and honors long hold-off requests.
    initial begin : result_sink
        int unsigned stall;
        int unsigned hold;
        int unsigned hold_seen;
        stall         = 0;
        hold          = 0;
        hold_seen     = 0;
        res_if.ready  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                board.check_result(res_if.new_value, res_if.out_row, res_if.out_col,
                                   res_if.last_of_grid);
                stall = snk_idle ? $urandom_range(0, 9) : 0;
            end
            @(negedge i_clk);
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold      = HOLD_CYCLES;
            end
            if (hold != 0) begin
                hold--;
                res_if.ready = 1'b0;
            end else if (stall != 0) begin
                stall--;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // Ends a run that hangs.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_explicit_diffusion_stencil_2d failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned n;
        int unsigned start;
        t_opcode     op;
        board             = new();
        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_addr          = '0;
        cfg_wdata         = '0;
        req_if.valid      = 1'b0;
        req_if.opcode     = OP_LOAD;
        req_if.cell_value = '0;
        src_idle          = 1'b0;
        snk_idle          = 1'b0;
        hold_asked        = 0;
        random_sent       = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Corner values on a 3x3 grid with both factors at full scale: saturation both ways.
        cfg_field(CFG_COEF_X, COEF_W, 16'hFFFF);
        cfg_field(CFG_COEF_Y, COEF_W, 16'hFFFF);
        cfg_field(CFG_BOUNDARY, DATA_W, 32'h80000000);
        cfg_field(CFG_GRID_ROWS, SIZE_W, 3);
        cfg_field(CFG_GRID_COLS, SIZE_W, 3);
        send_item(OP_LOAD, 32'sh7FFFFFFF);
        send_item(OP_LOAD, 32'sh80000000);
        send_item(OP_LOAD, 32'sh00000000);
        send_item(OP_LOAD, -32'sd1);
        send_item(OP_LOAD, 32'sd1);
        send_item(OP_LOAD, 32'sh7FFFFFFF);
        send_item(OP_LOAD, 32'sh80000000);
        send_item(OP_LOAD, 32'sh00010000);
        send_item(OP_LOAD, 32'shFFFF0000);
        flush_row();
        settle();

        // Sizes below the minimum clamp to a 2x2 grid; boundary at the top of the range.
        cfg_field(CFG_COEF_X, COEF_W, 16'h0000);
        cfg_field(CFG_COEF_Y, COEF_W, 16'h8000);
        cfg_field(CFG_BOUNDARY, DATA_W, 32'h7FFFFFFF);
        cfg_field(CFG_GRID_ROWS, SIZE_W, 1);
        cfg_field(CFG_GRID_COLS, SIZE_W, 0);
        send_item(OP_LOAD, 32'sh80000000);
        send_item(OP_LOAD, 32'sh7FFFFFFF);
        send_item(OP_LOAD, 32'sh12345678);
        send_item(OP_LOAD, 32'sh80000001);
        flush_row();
        settle();

        // Tallest grid cut short: the row count shrinks below the current row.
        src_idle = 1'b1;
        snk_idle = 1'b1;
        cfg_field(CFG_COEF_X, COEF_W, rand_coef());
        cfg_field(CFG_GRID_ROWS, SIZE_W, 1024);
        cfg_field(CFG_GRID_COLS, SIZE_W, 2);
        repeat (14) send_item(OP_LOAD, rand_cell());
        settle();
        cfg_field(CFG_GRID_ROWS, SIZE_W, 3);
        finish_grid();
        settle();

        // Widest grid with a row count above the maximum, cut short within row 0.
        cfg_field(CFG_GRID_ROWS, SIZE_W, 2047);
        cfg_field(CFG_GRID_COLS, SIZE_W, 1024);
        repeat (40) send_item(OP_LOAD, rand_cell());
        settle();
        cfg_field(CFG_GRID_COLS, SIZE_W, 5);
        cfg_field(CFG_GRID_ROWS, SIZE_W, 4);
        finish_grid();
        settle();

        // The result side holds off while requests keep coming, so the block backs up.
        src_idle = 1'b0;
        @(posedge i_clk);
        hold_asked++;
        run_grid();
        settle();

        // Random phases: whole grids, loose request mixes, resizes mid-grid and hold-offs.
        while (random_sent < RANDOM_ITEMS) begin
            src_idle = ($urandom_range(0, 2) != 0);
            snk_idle = ($urandom_range(0, 2) != 0);
            start    = board.accepted;
            pick     = $urandom_range(0, 99);
            if (pick < 60) begin
                random_config(1'b0);
                repeat ($urandom_range(1, 3)) run_grid();
            end else if (pick < 80) begin
                n = $urandom_range(5, 30);
                repeat (n) begin
                    op = ($urandom_range(0, 9) < 4) ? OP_FLUSH : OP_LOAD;
                    send_item(op, rand_cell());
                end
                finish_grid();
            end else if (pick < 95) begin
                n = $urandom_range(1, board.rows_in_use() * board.cols_in_use() - 1);
                repeat (n) send_item(OP_LOAD, rand_cell());
                settle();
                random_config(1'b1);
                finish_grid();
            end else begin
                src_idle = 1'b0;
                @(posedge i_clk);
                hold_asked++;
                run_grid();
            end
            settle();
            random_sent += board.accepted - start;
        end

        settle();
        if (board.mismatches == 0 && board.pending_cells.size() == 0) begin
            $display("tb_explicit_diffusion_stencil_2d passed");
        end else begin
            $display("tb_explicit_diffusion_stencil_2d failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/eds_pkg.sv
rtl/eds_in_if.sv
rtl/eds_out_if.sv
rtl/eds_ram.sv
rtl/eds_front.sv
rtl/eds_queue.sv
rtl/eds_back.sv
rtl/explicit_diffusion_stencil_2d.sv
rtl/eds_checker.sv
tb/tb_explicit_diffusion_stencil_2d.sv
